// ----- rtl/complex_integer_alu_assert.svh -----
// Assertion macros for the complex integer ALU checker.
// Expects signals clk and rst_n in the scope where a macro is used.
`ifndef COMPLEX_INTEGER_ALU_ASSERT_SVH
`define COMPLEX_INTEGER_ALU_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define CIA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("complex_integer_alu check failed");

// Next-cycle implication, checked out of reset
`define CIA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("complex_integer_alu check failed");

`endif

// ----- rtl/cia_pkg.sv -----
// Shared types and constants for the complex integer ALU.
// No dependencies.
package cia_pkg;

    typedef enum logic [2:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_DIV = 3'd3,
        CMD_NEG = 3'd4,
        CMD_EQ  = 3'd5,
        CMD_GT  = 3'd6
    } cmd_t;

    // Divider word width: magnitudes of numerator and |b|^2 fit 32 bits
    localparam int DIV_W = 32;

endpackage

// ----- rtl/cia_div_step.sv -----
// One restoring-division step: shifts one numerator bit into the remainder.
// Depends on cia_pkg.
module cia_div_step
    import cia_pkg::*;
(
    input  logic [DIV_W-1:0] rem_in,
    input  logic [DIV_W-1:0] qn_in,   // numerator bits left, quotient bits shifted in
    input  logic [DIV_W-1:0] den,
    output logic [DIV_W-1:0] rem_out,
    output logic [DIV_W-1:0] qn_out
);

    logic [DIV_W:0] trial;
    logic [DIV_W:0] diff;
    logic           ge;

    // Trial subtract of the divisor from the shifted remainder
    always_comb
    begin
        trial   = {rem_in, qn_in[DIV_W-1]};
        diff    = trial - {1'b0, den};
        ge      = (trial >= {1'b0, den});
        rem_out = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        qn_out  = {qn_in[DIV_W-2:0], ge};
    end

endmodule

// ----- rtl/complex_integer_alu.sv -----
// Pipeline to m_tvalid: 3 arithmetic stages, 32 divider stages, output register.
// Throughput: one transaction per cycle while s_tready is high, set by the fully
// pipelined multipliers and the one-bit-per-stage divider. A skid register behind
// the output lets input flow while one result waits; s_tready drops while it is full.
// Reset (rst_n, async, active low) clears all valid bits; no results in flight.
// Depends on cia_pkg and cia_div_step.
module complex_integer_alu
    import cia_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // a_re[15:0], a_im[31:16], b_re[47:32], b_im[63:48]
    input  logic [2:0]  s_tuser,   // command[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // res_re[31:0], res_im[63:32]
    output logic [1:0]  m_tuser    // compare_true[0], divide_by_zero[1]
);

    localparam int NDIV = DIV_W;

    logic out_valid_reg, skid_valid_reg;
    logic en;
    assign en = !skid_valid_reg;
    assign s_tready = en;

    // ---------------- Stage 1: operands and products ----------------
    logic               v1_reg;
    cmd_t               cmd1_reg;
    logic signed [15:0] ar1_reg, ai1_reg, br1_reg, bi1_reg;
    logic signed [31:0] p_arbr_reg, p_aibi_reg, p_arbi_reg, p_aibr_reg;
    logic signed [31:0] p_arar_reg, p_aiai_reg, p_brbr_reg, p_bibi_reg;
    logic signed [15:0] ar_in, ai_in, br_in, bi_in;

    assign ar_in = s_tdata[15:0];
    assign ai_in = s_tdata[31:16];
    assign br_in = s_tdata[47:32];
    assign bi_in = s_tdata[63:48];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmd1_reg   <= cmd_t'(s_tuser);
            ar1_reg    <= ar_in;
            ai1_reg    <= ai_in;
            br1_reg    <= br_in;
            bi1_reg    <= bi_in;
            p_arbr_reg <= ar_in * br_in;
            p_aibi_reg <= ai_in * bi_in;
            p_arbi_reg <= ar_in * bi_in;
            p_aibr_reg <= ai_in * br_in;
            p_arar_reg <= ar_in * ar_in;
            p_aiai_reg <= ai_in * ai_in;
            p_brbr_reg <= br_in * br_in;
            p_bibi_reg <= bi_in * bi_in;
        end
    end

    // ---------------- Stage 2: sums, plain results ----------------
    logic               v2_reg;
    logic               is_div2_reg, is_gt2_reg, is_eq2_reg, eq2_reg;
    logic [31:0]        res_re2_reg, res_im2_reg;
    logic signed [32:0] num_re2_reg, num_im2_reg;
    logic [31:0]        den2_reg, mag_a2_reg;
    logic [31:0]        res_re_next, res_im_next;
    logic [31:0]        ar_x, ai_x, br_x, bi_x;

    assign ar_x = {{16{ar1_reg[15]}}, ar1_reg};
    assign ai_x = {{16{ai1_reg[15]}}, ai1_reg};
    assign br_x = {{16{br1_reg[15]}}, br1_reg};
    assign bi_x = {{16{bi1_reg[15]}}, bi1_reg};

    always_comb
    begin
        res_re_next = 32'd0;
        res_im_next = 32'd0;
        unique case (cmd1_reg)
            CMD_ADD:
            begin
                res_re_next = ar_x + br_x;
                res_im_next = ai_x + bi_x;
            end
            CMD_SUB:
            begin
                res_re_next = ar_x - br_x;
                res_im_next = ai_x - bi_x;
            end
            CMD_MUL:
            begin
                res_re_next = p_arbr_reg - p_aibi_reg;
                res_im_next = p_arbi_reg + p_aibr_reg;
            end
            CMD_NEG:
            begin
                res_re_next = 32'd0 - ar_x;
                res_im_next = 32'd0 - ai_x;
            end
            default:
            begin
                res_re_next = 32'd0;
                res_im_next = 32'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            is_div2_reg <= (cmd1_reg == CMD_DIV);
            is_gt2_reg  <= (cmd1_reg == CMD_GT);
            is_eq2_reg  <= (cmd1_reg == CMD_EQ);
            eq2_reg     <= (ar1_reg == br1_reg) && (ai1_reg == bi1_reg);
            res_re2_reg <= res_re_next;
            res_im2_reg <= res_im_next;
            num_re2_reg <= {p_arbr_reg[31], p_arbr_reg} + {p_aibi_reg[31], p_aibi_reg};
            num_im2_reg <= {p_aibr_reg[31], p_aibr_reg} - {p_arbi_reg[31], p_arbi_reg};
            den2_reg    <= p_brbr_reg + p_bibi_reg;
            mag_a2_reg  <= p_arar_reg + p_aiai_reg;
        end
    end

    // ---------------- Stage 3 (divider entry): flags, magnitudes ----------------
    logic              dv_reg     [0:NDIV];
    logic              div_ok_reg [0:NDIV];
    logic              sgn_re_reg [0:NDIV];
    logic              sgn_im_reg [0:NDIV];
    logic              cmp_reg    [0:NDIV];
    logic              dz_reg     [0:NDIV];
    logic [31:0]       pres_re_reg[0:NDIV];
    logic [31:0]       pres_im_reg[0:NDIV];
    logic [DIV_W-1:0]  den_reg    [0:NDIV];
    logic [DIV_W-1:0]  rem_re_reg [0:NDIV];
    logic [DIV_W-1:0]  rem_im_reg [0:NDIV];
    logic [DIV_W-1:0]  qn_re_reg  [0:NDIV];
    logic [DIV_W-1:0]  qn_im_reg  [0:NDIV];
    logic signed [32:0] abs_re, abs_im;
    logic               zero_den;

    always_comb
    begin
        abs_re   = num_re2_reg[32] ? -num_re2_reg : num_re2_reg;
        abs_im   = num_im2_reg[32] ? -num_im2_reg : num_im2_reg;
        zero_den = (den2_reg == 32'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_reg[0] <= 1'b0;
        else if (en)
            dv_reg[0] <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_ok_reg[0]  <= is_div2_reg && !zero_den;
            dz_reg[0]      <= is_div2_reg && zero_den;
            cmp_reg[0]     <= (is_eq2_reg && eq2_reg) || (is_gt2_reg && (mag_a2_reg > den2_reg));
            sgn_re_reg[0]  <= num_re2_reg[32];
            sgn_im_reg[0]  <= num_im2_reg[32];
            pres_re_reg[0] <= res_re2_reg;
            pres_im_reg[0] <= res_im2_reg;
            den_reg[0]     <= den2_reg;
            rem_re_reg[0]  <= '0;
            rem_im_reg[0]  <= '0;
            qn_re_reg[0]   <= abs_re[DIV_W-1:0];
            qn_im_reg[0]   <= abs_im[DIV_W-1:0];
        end
    end

    // ---------------- Divider stages: one quotient bit per stage ----------------
    for (genvar k = 1; k <= NDIV; k++)
    begin : g_div
        logic [DIV_W-1:0] rre, rim, qre, qim;

        cia_div_step u_step_re (
            .rem_in (rem_re_reg[k-1]),
            .qn_in  (qn_re_reg[k-1]),
            .den    (den_reg[k-1]),
            .rem_out(rre),
            .qn_out (qre)
        );

        cia_div_step u_step_im (
            .rem_in (rem_im_reg[k-1]),
            .qn_in  (qn_im_reg[k-1]),
            .den    (den_reg[k-1]),
            .rem_out(rim),
            .qn_out (qim)
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_reg[k] <= 1'b0;
            else if (en)
                dv_reg[k] <= dv_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                div_ok_reg[k]  <= div_ok_reg[k-1];
                dz_reg[k]      <= dz_reg[k-1];
                cmp_reg[k]     <= cmp_reg[k-1];
                sgn_re_reg[k]  <= sgn_re_reg[k-1];
                sgn_im_reg[k]  <= sgn_im_reg[k-1];
                pres_re_reg[k] <= pres_re_reg[k-1];
                pres_im_reg[k] <= pres_im_reg[k-1];
                den_reg[k]     <= den_reg[k-1];
                rem_re_reg[k]  <= rre;
                rem_im_reg[k]  <= rim;
                qn_re_reg[k]   <= qre;
                qn_im_reg[k]   <= qim;
            end
        end
    end

    // ---------------- Final select: signed quotient or plain result ----------------
    logic [63:0] fin_data;
    logic [1:0]  fin_user;
    logic [31:0] q_re, q_im;

    always_comb
    begin
        q_re     = sgn_re_reg[NDIV] ? (32'd0 - qn_re_reg[NDIV]) : qn_re_reg[NDIV];
        q_im     = sgn_im_reg[NDIV] ? (32'd0 - qn_im_reg[NDIV]) : qn_im_reg[NDIV];
        fin_data = div_ok_reg[NDIV] ? {q_im, q_re}
                                    : {pres_im_reg[NDIV], pres_re_reg[NDIV]};
        fin_user = {dz_reg[NDIV], cmp_reg[NDIV]};
    end

    // ---------------- Output register with skid ----------------
    logic [63:0] out_data_reg, skid_data_reg;
    logic [1:0]  out_user_reg, skid_user_reg;
    logic        take, push;

    assign take = out_valid_reg && m_tready;
    assign push = dv_reg[NDIV] && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (out_valid_reg && !take)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (take)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_data_reg <= skid_data_reg;
                out_user_reg <= skid_user_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !take)
            begin
                skid_data_reg <= fin_data;
                skid_user_reg <= fin_user;
            end
            else
            begin
                out_data_reg <= fin_data;
                out_user_reg <= fin_user;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

// ----- rtl/cia_checker.sv -----
// Port-level checker for complex_integer_alu, bound to the top level.
// Depends on complex_integer_alu_assert.svh.
`include "complex_integer_alu_assert.svh"

module cia_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // A stalled result holds
    `CIA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // Compare and zero-divisor flags never together
    `CIA_ASSERT_IMPL(a_flags_excl, m_tvalid, !(m_tuser[0] && m_tuser[1]))
    // Zero divisor gives zero parts
    `CIA_ASSERT_IMPL(a_dz_zero, m_tvalid && m_tuser[1], m_tdata == 64'd0)
    // Compare results carry zero parts
    `CIA_ASSERT_IMPL(a_cmp_zero, m_tvalid && m_tuser[0], m_tdata == 64'd0)

endmodule

bind complex_integer_alu cia_checker u_cia_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);

// ----- tb/sv/complex_integer_alu_checker.sv -----
// Scoreboard for the complex integer ALU: watches both stream channels,
// predicts each result from the accepted operands and compares. Depends on cia_pkg.
module complex_integer_alu_checker
    import cia_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic [1:0]  m_tuser,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic               cmp;
        logic               dz;
    } alu_result_t;

    alu_result_t expected_q[$];

    // Gaussian integer arithmetic on one operand pair
    function automatic alu_result_t compute_result(logic [2:0] op, logic [63:0] d);
        longint ar, ai, br, bi, den, rr, ri;
        alu_result_t r;
        ar = longint'($signed(d[15:0]));
        ai = longint'($signed(d[31:16]));
        br = longint'($signed(d[47:32]));
        bi = longint'($signed(d[63:48]));
        rr = 0;
        ri = 0;
        r = '0;
        case (op)
            CMD_ADD: begin rr = ar + br; ri = ai + bi; end
            CMD_SUB: begin rr = ar - br; ri = ai - bi; end
            CMD_MUL:
            begin
                rr = ar * br - ai * bi;
                ri = ar * bi + ai * br;
            end
            CMD_DIV:
            begin
                den = br * br + bi * bi;
                if (den == 0)
                    r.dz = 1'b1;
                else
                begin
                    // SV integer division truncates toward zero
                    rr = (ar * br + ai * bi) / den;
                    ri = (ai * br - ar * bi) / den;
                end
            end
            CMD_NEG: begin rr = -ar; ri = -ai; end
            CMD_EQ:  r.cmp = (ar == br) && (ai == bi);
            CMD_GT:  r.cmp = (ar * ar + ai * ai) > (br * br + bi * bi);
            default: ;
        endcase
        r.re = rr[31:0];
        r.im = ri[31:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    // Sample transactions on both channels
    always @(posedge clk)
    begin
        alu_result_t e;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                expected_q.push_back(compute_result(s_tuser, s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (expected_q.size() == 0)
                    report_mismatch("unexpected result", 0, 0);
                else
                begin
                    e = expected_q.pop_front();
                    if ($signed(m_tdata[31:0]) != e.re)
                        report_mismatch("res_re", $signed(m_tdata[31:0]), e.re);
                    if ($signed(m_tdata[63:32]) != e.im)
                        report_mismatch("res_im", $signed(m_tdata[63:32]), e.im);
                    if (m_tuser[0] != e.cmp)
                        report_mismatch("compare_true", m_tuser[0], e.cmp);
                    if (m_tuser[1] != e.dz)
                        report_mismatch("divide_by_zero", m_tuser[1], e.dz);
                end
            end
            pending = expected_q.size();
        end
    end

endmodule

// ----- tb/sv/complex_integer_alu_tb.sv -----
// Top of the complex integer ALU testbench: clock, reset, stream stimulus, verdict.
// Depends on cia_pkg, complex_integer_alu and complex_integer_alu_checker.
module complex_integer_alu_tb;
    import cia_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY     = 36;
    localparam int RANDOM_ITEMS = 1630;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;
    int          errors;
    int          pending;
    bit          quiet;     // no idling in the last part of the run

    complex_integer_alu uut (.*);

    complex_integer_alu_checker chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    // Result side: random stall bursts
    initial
    begin
        int n;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!quiet && $urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 19);
                m_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Send one operand transaction, with an optional idle burst first
    task automatic send_item(logic [2:0] op, logic [15:0] ar, logic [15:0] ai,
                             logic [15:0] br, logic [15:0] bi);
        int n;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            n = $urandom_range(1, 19);
            s_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {bi, br, ai, ar};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    function automatic logic [15:0] rand_part();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h8001;
            3: return 16'($signed($urandom_range(0, 8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [15:0] ar, ai, br, bi;
        logic [2:0]  op;
        quiet    = 1'b0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_ADD;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, every command, zero divisor, unused command
        send_item(CMD_ADD, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_item(CMD_SUB, 16'h8001, 16'h7FFF, 16'h7FFF, 16'h8001);
        send_item(CMD_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_item(CMD_MUL, 16'h7FFF, 16'h8001, 16'h8001, 16'h7FFF);
        send_item(CMD_DIV, 16'd7, 16'hFFFD, 16'd0, 16'd0);
        send_item(CMD_DIV, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_item(CMD_DIV, 16'hFFF9, 16'd5, 16'd2, 16'hFFFF);
        send_item(CMD_DIV, 16'h7FFF, 16'h8001, 16'd1, 16'd0);
        send_item(CMD_DIV, 16'd1, 16'd1, 16'h7FFF, 16'h7FFF);
        send_item(CMD_NEG, 16'h8000, 16'h7FFF, 16'd0, 16'd0);
        send_item(CMD_EQ, 16'h1234, 16'h8000, 16'h1234, 16'h8000);
        send_item(CMD_EQ, 16'h1234, 16'h8000, 16'h1234, 16'h8001);
        send_item(CMD_GT, 16'd3, 16'd4, 16'd4, 16'd3);
        send_item(CMD_GT, 16'd3, 16'd5, 16'd4, 16'd3);
        send_item(CMD_GT, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
        send_item(3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(CMD_ADD, 16'd0, 16'd0, 16'd0, 16'd0);

        // Random: mix of corner values and full-range parts
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS - 200)
                quiet = 1'b1;
            op = 3'($urandom_range(0, 7));
            ar = rand_part();
            ai = rand_part();
            br = rand_part();
            bi = rand_part();
            if (op == CMD_EQ && $urandom_range(0, 1))
            begin
                br = ar;
                bi = ai;
            end
            if (op == CMD_DIV && $urandom_range(0, 9) == 0)
            begin
                br = '0;
                bi = '0;
            end
            send_item(op, ar, ai, br, bi);
        end
        s_tvalid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
